### rtl/tsfm_pkg.sv
// Shared types and constants of the touch sample filter and mapper.
// Holds the input and result item structs, register indexes and reset values.
// Depends on nothing; used by touch_sample_filter_mapper.
package tsfm_pkg;

  // Field widths.
  localparam int RAW_W     = 12;
  localparam int PT_W      = 11;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * RAW_W;
  localparam int STEP_W    = 5;

  // Largest coordinate the result fields hold.
  localparam logic [RAW_W-1:0] PT_MAX = 12'd2047;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESH  = 3'd6;

  // Register reset values.
  localparam logic [RAW_W-1:0] RST_SCREEN_WIDTH  = 12'd320;
  localparam logic [RAW_W-1:0] RST_SCREEN_HEIGHT = 12'd240;
  localparam logic [RAW_W-1:0] RST_RAW_MIN       = 12'd300;
  localparam logic [RAW_W-1:0] RST_RAW_MAX       = 12'd3800;
  localparam logic [RAW_W-1:0] RST_PRESS_THRESH  = 12'd200;

  // One raw touch sample.
  typedef struct packed {
    logic [RAW_W-1:0] x_raw;
    logic [RAW_W-1:0] y_raw;
    logic [RAW_W-1:0] pressure_raw;
    logic             reads_ok;
  } tsfm_in_t;

  // One reported touch point.
  typedef struct packed {
    logic            pressed;
    logic [PT_W-1:0] point_x;
    logic [PT_W-1:0] point_y;
  } tsfm_out_t;

endpackage

### rtl/touch_sample_filter_mapper.sv
// Touch sample filter and screen mapper, top level.
// Uses tsfm_pkg for the item structs, register indexes and reset values.
// A press runs through one bit-serial datapath per axis: the ring is summed
// one entry per cycle, the average is formed by a restoring divider that
// retires one quotient bit per cycle, the scale product is built by a
// shift-add multiplier one bit per cycle, and the same divider then retires
// the 24-bit scale quotient; a release goes straight to the result load.
// One item is worked on at a time; the next one can be accepted in the cycle
// after the previous result is loaded into the output register, even if it
// has not been taken yet. Configuration writes are accepted in every cycle.
module touch_sample_filter_mapper #(
  parameter int AVG_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tsfm_pkg::tsfm_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tsfm_pkg::tsfm_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsfm_pkg::RAW_W-1:0]          cfg_data
);
  import tsfm_pkg::*;

  localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W = RAW_W + $clog2(AVG_DEPTH);
  localparam int PAD_W = PROD_W - SUM_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_AVG   = 3'd2;
  localparam logic [2:0] ST_CLAMP = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  // Configuration registers.
  logic [RAW_W-1:0] sw_r, sh_r, xmin_r, xmax_r, ymin_r, ymax_r, thr_r;

  // Averaging ring and hold state.
  logic [RAW_W-1:0] ring_x_r [AVG_DEPTH];
  logic [RAW_W-1:0] ring_y_r [AVG_DEPTH];
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [PT_W-1:0]  held_x_r, held_y_r;

  // Sequencer and current item.
  logic [2:0]        state_r;
  logic [STEP_W-1:0] cnt_r;
  logic              press_r;
  logic [RAW_W-1:0]  cur_x_r, cur_y_r;

  // Per-axis lanes: index 0 is X, index 1 is Y.
  logic [SUM_W-1:0]  sum_r     [2];
  logic [SUM_W-1:0]  sum_nxt   [2];
  logic [RAW_W-1:0]  rem_r     [2];
  logic [RAW_W-1:0]  rem_nxt   [2];
  logic [PROD_W-1:0] dvd_r     [2];
  logic [PROD_W-1:0] dvd_nxt   [2];
  logic [RAW_W-1:0]  dsr_r     [2];
  logic [RAW_W-1:0]  mhi_r     [2];
  logic [RAW_W-1:0]  mhi_nxt   [2];
  logic [RAW_W-1:0]  mlo_r     [2];
  logic [RAW_W-1:0]  mlo_nxt   [2];
  logic [RAW_W-1:0]  mcand_r   [2];
  logic [RAW_W-1:0]  mcand_nxt [2];
  logic [RAW_W-1:0]  lane_lo   [2];
  logic [RAW_W-1:0]  lane_hi   [2];
  logic [RAW_W-1:0]  lane_sz   [2];
  logic [RAW_W-1:0]  lane_add  [2];
  logic [RAW_W-1:0]  lane_q    [2];
  logic              lane_deg  [2];
  logic [RAW_W-1:0]  avg_v     [2];
  logic [RAW_W:0]    div_t     [2];
  logic [RAW_W:0]    div_r     [2];
  logic              div_ge    [2];
  logic [RAW_W:0]    mul_t     [2];

  // Result staging.
  logic              out_valid_r;
  tsfm_out_t         out_r;
  logic              in_press;
  logic [RAW_W-1:0]  ent_x, ent_y;
  logic [RAW_W-1:0]  fit_vx, fit_vy;
  logic signed [RAW_W:0] py_s;
  logic [PT_W-1:0]   fit_x, fit_y;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // A press needs good conversions and pressure strictly above threshold.
  assign in_press = in_data.reads_ok && (in_data.pressure_raw > thr_r);

  assign pos_nxt = (pos_r == IDX_W'(AVG_DEPTH - 1)) ? '0 : pos_r + 1'b1;

  // Ring entry under the sum count; a zero X entry stands for the current item.
  assign ent_x = ring_x_r[cnt_r[IDX_W-1:0]];
  assign ent_y = ring_y_r[cnt_r[IDX_W-1:0]];

  // Per-lane step logic: accumulate, divide one bit, clamp, multiply one bit.
  always_comb begin
    lane_lo[0] = xmin_r;
    lane_hi[0] = xmax_r;
    lane_sz[0] = sw_r;
    lane_lo[1] = ymin_r;
    lane_hi[1] = ymax_r;
    lane_sz[1] = sh_r;
    lane_add[0] = (ent_x == '0) ? cur_x_r : ent_x;
    lane_add[1] = (ent_x == '0) ? cur_y_r : ent_y;
    for (int l = 0; l < 2; l++) begin
      sum_nxt[l] = sum_r[l] + SUM_W'(lane_add[l]);

      // Restoring divider step.
      div_t[l]   = {rem_r[l], dvd_r[l][PROD_W-1]};
      div_ge[l]  = (div_t[l] >= {1'b0, dsr_r[l]});
      div_r[l]   = div_ge[l] ? (div_t[l] - {1'b0, dsr_r[l]}) : div_t[l];
      rem_nxt[l] = div_r[l][RAW_W-1:0];
      dvd_nxt[l] = {dvd_r[l][PROD_W-2:0], div_ge[l]};

      // Clamp the average to the raw window and take the offset from min.
      avg_v[l] = dvd_r[l][RAW_W-1:0];
      if (avg_v[l] < lane_lo[l]) begin
        mcand_nxt[l] = '0;
      end else if (avg_v[l] > lane_hi[l]) begin
        mcand_nxt[l] = lane_hi[l] - lane_lo[l];
      end else begin
        mcand_nxt[l] = avg_v[l] - lane_lo[l];
      end
      lane_deg[l] = (lane_hi[l] <= lane_lo[l]);

      // Shift-add multiplier step, multiplier bits leave at the bottom.
      mul_t[l]   = {1'b0, mhi_r[l]} + (mlo_r[l][0] ? {1'b0, mcand_r[l]} : '0);
      mhi_nxt[l] = mul_t[l][RAW_W:1];
      mlo_nxt[l] = {mul_t[l][0], mlo_r[l][RAW_W-1:1]};

      lane_q[l] = lane_deg[l] ? '0 : dvd_r[l][RAW_W-1:0];
    end
  end

  // Fit the scaled point to the screen; Y is inverted first.
  always_comb begin
    fit_vx = (lane_q[0] >= sw_r) ? (sw_r - 1'b1) : lane_q[0];
    if (sw_r == '0) begin
      fit_x = '0;
    end else if (fit_vx > PT_MAX) begin
      fit_x = PT_MAX[PT_W-1:0];
    end else begin
      fit_x = fit_vx[PT_W-1:0];
    end

    py_s   = $signed({1'b0, sh_r}) - 13'sd1 - $signed({1'b0, lane_q[1]});
    fit_vy = (py_s[RAW_W-1:0] >= sh_r) ? (sh_r - 1'b1) : py_s[RAW_W-1:0];
    if (sh_r == '0 || py_s < 0) begin
      fit_y = '0;
    end else if (fit_vy > PT_MAX) begin
      fit_y = PT_MAX[PT_W-1:0];
    end else begin
      fit_y = fit_vy[PT_W-1:0];
    end
  end

  // Configuration, ring and sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r        <= RST_SCREEN_WIDTH;
      sh_r        <= RST_SCREEN_HEIGHT;
      xmin_r      <= RST_RAW_MIN;
      xmax_r      <= RST_RAW_MAX;
      ymin_r      <= RST_RAW_MIN;
      ymax_r      <= RST_RAW_MAX;
      thr_r       <= RST_PRESS_THRESH;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_x_r[i] <= '0;
        ring_y_r[i] <= '0;
      end
      pos_r       <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      press_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Register writes.
      if (cfg_valid) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  sw_r   <= cfg_data;
          REG_SCREEN_HEIGHT: sh_r   <= cfg_data;
          REG_X_RAW_MIN:     xmin_r <= cfg_data;
          REG_X_RAW_MAX:     xmax_r <= cfg_data;
          REG_Y_RAW_MIN:     ymin_r <= cfg_data;
          REG_Y_RAW_MAX:     ymax_r <= cfg_data;
          REG_PRESS_THRESH:  thr_r  <= cfg_data;
          default: ;
        endcase
      end

      // The result item leaves when taken; in ST_FIN a taken item is replaced
      // by the new load below.
      if (out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cur_x_r <= in_data.x_raw;
            cur_y_r <= in_data.y_raw;
            press_r <= in_press;
            if (in_press) begin
              ring_x_r[pos_r] <= in_data.x_raw;
              ring_y_r[pos_r] <= in_data.y_raw;
              pos_r           <= pos_nxt;
              sum_r[0]        <= '0;
              sum_r[1]        <= '0;
              cnt_r           <= '0;
              state_r         <= ST_SUM;
            end else begin
              for (int i = 0; i < AVG_DEPTH; i++) begin
                ring_x_r[i] <= '0;
                ring_y_r[i] <= '0;
              end
              state_r <= ST_FIN;
            end
          end
        end

        // One ring entry per cycle into each lane's sum.
        ST_SUM: begin
          for (int l = 0; l < 2; l++) begin
            sum_r[l] <= sum_nxt[l];
          end
          if (cnt_r == STEP_W'(AVG_DEPTH - 1)) begin
            for (int l = 0; l < 2; l++) begin
              rem_r[l] <= '0;
              dvd_r[l] <= {sum_nxt[l], PAD_W'(0)};
              dsr_r[l] <= RAW_W'(AVG_DEPTH);
            end
            cnt_r   <= '0;
            state_r <= ST_AVG;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        // Average: one quotient bit per cycle.
        ST_AVG: begin
          for (int l = 0; l < 2; l++) begin
            rem_r[l] <= rem_nxt[l];
            dvd_r[l] <= dvd_nxt[l];
          end
          if (cnt_r == STEP_W'(SUM_W - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_CLAMP;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        // Window clamp; set up the multiplier and the scale divisor.
        ST_CLAMP: begin
          for (int l = 0; l < 2; l++) begin
            mcand_r[l] <= mcand_nxt[l];
            mhi_r[l]   <= '0;
            mlo_r[l]   <= lane_sz[l];
            dsr_r[l]   <= lane_hi[l] - lane_lo[l];
          end
          state_r <= ST_MUL;
        end

        // Offset times screen size, one multiplier bit per cycle.
        ST_MUL: begin
          for (int l = 0; l < 2; l++) begin
            mhi_r[l] <= mhi_nxt[l];
            mlo_r[l] <= mlo_nxt[l];
          end
          if (cnt_r == STEP_W'(RAW_W - 1)) begin
            for (int l = 0; l < 2; l++) begin
              rem_r[l] <= '0;
              dvd_r[l] <= {mhi_nxt[l], mlo_nxt[l]};
            end
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        // Product over window span, one quotient bit per cycle.
        ST_DIV: begin
          for (int l = 0; l < 2; l++) begin
            rem_r[l] <= rem_nxt[l];
            dvd_r[l] <= dvd_nxt[l];
          end
          if (cnt_r == STEP_W'(PROD_W - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        // Load the result item once the output register is free.
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_r.pressed <= press_r;
            if (press_r) begin
              held_x_r      <= fit_x;
              held_y_r      <= fit_y;
              out_r.point_x <= fit_x;
              out_r.point_y <= fit_y;
            end else begin
              out_r.point_x <= held_x_r;
              out_r.point_y <= held_y_r;
            end
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A finished item never overwrites a result that is still waiting.
  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=> (state_r == ST_FIN))
    else $error("finished item overwrote a waiting result");

  // The X lane divider remainder stays below a nonzero divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_AVG || state_r == ST_DIV) && dsr_r[0] != '0)
      |-> (rem_r[0] < dsr_r[0]))
    else $error("divider remainder out of range");

  // An accepted item always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted item did not start");

endmodule
